[rtl/sti_pkg.sv]
// ----------------------------------------------------------------------------
// sti_pkg
// Types and codes shared by the sorted table block and its command checker.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_SORTED = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_OPEN,
    OP_SEARCH,
    OP_REMOVE,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_RD_RD,
    S_RD_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [15:0] tag;
    logic [5:0]  index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  position;
    logic [6:0]  count;
    logic [63:0] read_key;
    logic [15:0] read_tag;
  } out_item_t;

  typedef struct packed {
    status_t status;
    op_t     op;
  } chk_t;

endpackage

[rtl/sorted_table_insert_remove.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_remove
// Bounded ordered table of key/tag entries with append, insert, remove,
// sorted insert by binary search, and read.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item gives one
// result on out_item, marked by out_valid for exactly one cycle. The receiver
// cannot stall, so results are never held back.
// All entries live in one single-port memory with a registered read, and one
// key comparator serves the binary search. Steps of each command:
//   error or unknown command: strobes the status without touching the memory.
//   read: reads the entry at the index and returns its key and tag.
//   append or insert at slot s: shifts entries from s upward by one, then writes s.
//   remove at index i: shifts entries above i down by one, then lowers the count.
//   sorted insert: binary search reads and compares one probe at a time,
//   then the insert steps run at the slot found.
// Each moved entry is read from the memory and then written one slot over.
// Reset clears the entry count, the sequencer and the result strobe; the memory
// is not cleared and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 64,
  parameter int TAG_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sti_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output sti_pkg::out_item_t out_item
);
  import sti_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int EW = KEY_WIDTH + TAG_WIDTH;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      res_r, res_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic [AW-1:0]  slot_r, slot_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [AW-1:0]  probe_r, probe_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hix_r, hix_nxt;

  chk_t                 chk;
  logic [KEY_WIDTH-1:0] in_key;
  logic [TAG_WIDTH-1:0] in_tag;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic [CW-1:0]        lo_c;
  logic [CW-1:0]        hix_c;
  logic [CW-1:0]        span_c;

  sti_cmd_check #(
    .DEPTH(DEPTH)
  ) u_check (
    .cmd   (in_item.cmd),
    .index (in_item.index),
    .count (count_r),
    .chk   (chk)
  );

  assign in_key = KEY_WIDTH'(in_item.key);
  assign in_tag = TAG_WIDTH'(in_item.tag);
  assign rd_key = rd_data_r[EW-1:TAG_WIDTH];
  assign rd_tag = rd_data_r[TAG_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    slot_nxt      = slot_r;
    ptr_nxt       = ptr_r;
    probe_nxt     = probe_r;
    lo_nxt        = lo_r;
    hix_nxt       = hix_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data_r;
    lo_c          = lo_r;
    hix_c         = hix_r;
    span_c        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_key;
          tag_nxt = in_tag;
          res_nxt = '{status: chk.status, position: '0, count: 7'(count_r),
                      read_key: '0, read_tag: '0};
          ptr_nxt = AW'(count_r);
          case (chk.op)
            OP_OPEN: begin
              if (in_item.cmd == CMD_APPEND) begin
                slot_nxt = AW'(count_r);
              end else if (in_item.cmd == CMD_INSERT) begin
                slot_nxt = AW'(in_item.index);
              end else begin
                slot_nxt = '0;
              end
              state_nxt = S_UP_RD;
            end
            OP_SEARCH: begin
              lo_nxt    = '0;
              hix_nxt   = count_r;
              probe_nxt = AW'(count_r >> 1);
              state_nxt = S_PROBE;
            end
            OP_REMOVE: begin
              ptr_nxt          = AW'(in_item.index);
              res_nxt.position = in_item.index;
              state_nxt        = S_DN_RD;
            end
            OP_READ: begin
              ptr_nxt          = AW'(in_item.index);
              res_nxt.position = in_item.index;
              state_nxt        = S_RD_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PROBE: begin
        rd_en     = 1'b1;
        rd_addr   = probe_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_key == key_r) begin
          slot_nxt  = probe_r;
          state_nxt = S_UP_RD;
        end else begin
          if (key_r < rd_key) begin
            hix_c = CW'(probe_r);
          end else begin
            lo_c = CW'(probe_r) + CW'(1);
          end
          lo_nxt  = lo_c;
          hix_nxt = hix_c;
          if (lo_c >= hix_c) begin
            slot_nxt  = AW'(lo_c);
            state_nxt = S_UP_RD;
          end else begin
            span_c    = (hix_c - lo_c - CW'(1)) >> 1;
            probe_nxt = AW'(lo_c + span_c);
            state_nxt = S_PROBE;
          end
        end
      end
      S_UP_RD: begin
        if (ptr_r == slot_r) begin
          wr_en            = 1'b1;
          wr_addr          = slot_r;
          wr_data          = {key_r, tag_r};
          count_nxt        = count_r + CW'(1);
          res_nxt.position = 6'(slot_r);
          res_nxt.count    = 7'(count_r + CW'(1));
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r - AW'(1);
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        ptr_nxt   = ptr_r - AW'(1);
        state_nxt = S_UP_RD;
      end
      S_DN_RD: begin
        if (CW'(ptr_r) + CW'(1) == count_r) begin
          count_nxt     = count_r - CW'(1);
          res_nxt.count = 7'(count_r - CW'(1));
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r + AW'(1);
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = S_DN_RD;
      end
      S_RD_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_r;
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        res_nxt.read_key = 64'(rd_key);
        res_nxt.read_tag = 16'(rd_tag);
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r != S_IDLE && state_r != S_RD_WAIT && out_valid_nxt) begin
      res_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    key_r   <= key_nxt;
    tag_r   <= tag_nxt;
    slot_r  <= slot_nxt;
    ptr_r   <= ptr_nxt;
    probe_r <= probe_nxt;
    lo_r    <= lo_nxt;
    hix_r   <= hix_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

`ifndef SYNTHESIS
  a_err_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && chk.op == OP_NONE) |=> out_valid)
    else $error("rejected item gave no result strobe");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("memory written while idle");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("entry count changed without a result");
`endif

endmodule

[rtl/sti_cmd_check.sv]
// ----------------------------------------------------------------------------
// sti_cmd_check
// Decodes a command against the entry count into a status and an operation.
// ----------------------------------------------------------------------------
module sti_cmd_check #(
  parameter int DEPTH = 64
) (
  input  logic [2:0]                    cmd,
  input  logic [5:0]                    index,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  output sti_pkg::chk_t                 chk
);
  import sti_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;
  logic          full;
  logic          empty;

  assign idx_x = XW'(index);
  assign cnt_x = XW'(count);
  assign full  = (count >= CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    chk.status = ST_OK;
    chk.op     = OP_NONE;
    case (cmd)
      CMD_APPEND, CMD_INSERT, CMD_SORTED: begin
        if (full) begin
          chk.status = ST_FULL;
        end else if (cmd == CMD_INSERT && idx_x > cnt_x) begin
          chk.status = ST_RANGE;
        end else if (cmd == CMD_SORTED && !empty) begin
          chk.op = OP_SEARCH;
        end else begin
          chk.op = OP_OPEN;
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (empty) begin
          chk.status = ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          chk.status = ST_RANGE;
        end else if (cmd == CMD_READ) begin
          chk.op = OP_READ;
        end else begin
          chk.op = OP_REMOVE;
        end
      end
      default: begin
        chk.op = OP_NONE;
      end
    endcase
  end

endmodule
